[design/ctwb_pkg.sv]
package ctwb_pkg;

	typedef logic signed [63:0] q32_t;
	typedef logic [2:0][63:0] resp_t;
	typedef logic [0:2][0:2][63:0] mat_t;

	// pipeline depths of the arithmetic units
	localparam int L_MUL = 4;
	localparam int QBITS = 63;
	localparam int L_DIV = QBITS + 2;

	localparam q32_t QONE = 64'sd4294967296;
	localparam q32_t QMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	// daylight-locus coefficients, 4000 to 7000 K
	localparam q32_t N0 = (-64'sd46070 * QONE) / 64'sd10000;
	localparam q32_t N1 = (64'sd29678 * QONE) / 64'sd10000;
	localparam q32_t N2 = (64'sd9911 * QONE) / 64'sd100000;
	localparam q32_t N3 = (64'sd244063 * QONE) / 64'sd1000000;
	// daylight-locus coefficients, all other temperatures
	localparam q32_t F0 = (-64'sd20064 * QONE) / 64'sd10000;
	localparam q32_t F1 = (64'sd19018 * QONE) / 64'sd10000;
	localparam q32_t F2 = (64'sd24748 * QONE) / 64'sd100000;
	localparam q32_t F3 = (64'sd237040 * QONE) / 64'sd1000000;
	// y from x
	localparam q32_t CM3 = -64'sd3 * QONE;
	localparam q32_t C287 = (64'sd287 * QONE) / 64'sd100;
	localparam q32_t C275 = (64'sd275 * QONE) / 64'sd1000;

	localparam int T_MIN = 1000;
	localparam int T_NEAR_LO = 4000;
	localparam int T_NEAR_HI = 7000;
	localparam int T_TARGET = 6504;

	// bradford cone matrix
	localparam mat_t BRAD = '{
		'{64'((64'sd8951 * QONE) / 64'sd10000), 64'((64'sd2664 * QONE) / 64'sd10000),
			64'((-64'sd1614 * QONE) / 64'sd10000)},
		'{64'((-64'sd7502 * QONE) / 64'sd10000), 64'((64'sd17135 * QONE) / 64'sd10000),
			64'((64'sd367 * QONE) / 64'sd10000)},
		'{64'((64'sd389 * QONE) / 64'sd10000), 64'((-64'sd685 * QONE) / 64'sd10000),
			64'((64'sd10296 * QONE) / 64'sd10000)}
	};

	// magnitude of a signed value as unsigned
	function automatic logic [63:0] f_mag(input q32_t a);
		return a[63] ? (64'd0 - 64'(a)) : 64'(a);
	endfunction

	// truncating q32 multiply with saturation
	function automatic q32_t f_qmul(input q32_t a, input q32_t b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] m;
		logic [63:0] mag;
		ua = f_mag(a);
		ub = f_mag(b);
		m = ((64'(ua[63:32]) * 64'(ub[63:32])) << 32) + 64'(ua[63:32]) * 64'(ub[31:0])
			+ 64'(ua[31:0]) * 64'(ub[63:32]) + ((64'(ua[31:0]) * 64'(ub[31:0])) >> 32);
		mag = m[63] ? 64'(QMAX) : m;
		return (a[63] ^ b[63]) ? q32_t'(64'd0 - mag) : q32_t'(mag);
	endfunction

	// truncating q32 divide, shift and subtract, for constant set-up
	function automatic q32_t f_qdiv(input q32_t a, input q32_t b);
		logic [63:0] ua;
		logic [63:0] ub;
		logic [63:0] r;
		logic [64:0] r2;
		logic [62:0] q;
		logic neg;
		ua = f_mag(a);
		ub = f_mag(b);
		neg = a[63] ^ b[63];
		q = '0;
		r = 64'(ua[63:31]);
		if (ub == 64'd0) begin
			return a[63] ? -QMAX : QMAX;
		end
		if (64'(ua[63:31]) >= ub) begin
			return neg ? -QMAX : QMAX;
		end
		for (int i = QBITS - 1; i >= 0; i--) begin
			r2 = {r, (i >= 32) ? ua[i - 32] : 1'b0};
			if (r2 >= {1'b0, ub}) begin
				r2 = r2 - {1'b0, ub};
				q[i] = 1'b1;
			end
			r = r2[63:0];
		end
		return neg ? q32_t'(64'd0 - {1'b0, q}) : q32_t'({1'b0, q});
	endfunction

	// cone response of one temperature, for the fixed target
	function automatic resp_t f_cone(input int t);
		q32_t s;
		q32_t s2;
		q32_t s3;
		q32_t x;
		q32_t y;
		q32_t bx;
		q32_t bz;
		logic near;
		resp_t r;
		near = (t >= T_NEAR_LO) && (t <= T_NEAR_HI);
		s = f_qdiv(64'sd1000, q32_t'(t));
		s2 = f_qmul(s, s);
		s3 = f_qmul(s2, s);
		x = f_qmul(near ? N0 : F0, s3) + f_qmul(near ? N1 : F1, s2)
			+ f_qmul(near ? N2 : F2, s) + (near ? N3 : F3);
		y = f_qmul(CM3, f_qmul(x, x)) + f_qmul(C287, x) - C275;
		bx = f_qdiv(x, y);
		bz = f_qdiv(QONE - x - y, y);
		for (int i = 0; i < 3; i++) begin
			r[i] = 64'(f_qmul(q32_t'(BRAD[i][0]), bx) + q32_t'(BRAD[i][1])
				+ f_qmul(q32_t'(BRAD[i][2]), bz));
		end
		return r;
	endfunction

	// target white point response
	localparam resp_t DST = f_cone(T_TARGET);

endpackage

[design/ctwb_delay.sv]
module ctwb_delay #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	// shift line that advances with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

[design/ctwb_qmul.sv]
module ctwb_qmul import ctwb_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q32_t a,
	input  q32_t b,
	output q32_t p
);

	logic [63:0] ua_s1, ub_s1;
	logic        neg_s1, neg_s2, neg_s3;
	logic [63:0] hh_s2, hl_s2, lh_s2, ll_s2;
	logic [63:0] m_s3;
	q32_t        p_s4;

	// magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1 <= f_mag(a);
			ub_s1 <= f_mag(b);
			neg_s1 <= a[63] ^ b[63];
		end
	end

	// four 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[63:32]);
			hl_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[31:0]);
			lh_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[63:32]);
			ll_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[31:0]);
			neg_s2 <= neg_s1;
		end
	end

	// align partial products, keep 32 fraction bits
	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= (hh_s2 << 32) + hl_s2 + lh_s2 + (ll_s2 >> 32);
			neg_s3 <= neg_s2;
		end
	end

	// saturate and apply sign
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s3) begin
				p_s4 <= m_s3[63] ? -QMAX : q32_t'(64'd0 - m_s3);
			end else begin
				p_s4 <= m_s3[63] ? QMAX : q32_t'(m_s3);
			end
		end
	end

	assign p = p_s4;

endmodule

[design/ctwb_qdiv.sv]
module ctwb_qdiv import ctwb_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q32_t a,
	input  q32_t b,
	output q32_t q
);

	logic [63:0]      ua_p   [QBITS];
	logic [63:0]      ub_p   [QBITS];
	logic             neg_p  [QBITS+1];
	logic             aneg_p [QBITS+1];
	logic [63:0]      rem_p  [1:QBITS];
	logic [QBITS-1:0] quo_p  [1:QBITS];
	logic             sat_p  [1:QBITS];
	logic             zero_p [1:QBITS];
	q32_t             res_s;

	// magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			ua_p[0] <= f_mag(a);
			ub_p[0] <= f_mag(b);
			neg_p[0] <= a[63] ^ b[63];
			aneg_p[0] <= a[63];
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QBITS; k++) begin : g_bit
		localparam int BI = QBITS - 1 - k;
		logic [63:0] r_in;
		logic        nb;
		logic [64:0] r2;
		logic        ge;

		if (k == 0) begin : g_first
			assign r_in = 64'(ua_p[0][63:31]);
		end else begin : g_next
			assign r_in = rem_p[k];
		end

		if (BI >= 32) begin : g_num
			assign nb = ua_p[k][BI-32];
		end else begin : g_zero
			assign nb = 1'b0;
		end

		assign r2 = {r_in, nb};
		assign ge = r2 >= {1'b0, ub_p[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1] <= ge ? 64'(r2 - {1'b0, ub_p[k]}) : r2[63:0];
				neg_p[k+1] <= neg_p[k];
				aneg_p[k+1] <= aneg_p[k];
			end
		end

		// overflow and zero divisor flags come from the first stage
		if (k == 0) begin : g_flags
			always_ff @(posedge clk) begin
				if (en) begin
					quo_p[1] <= QBITS'(ge);
					sat_p[1] <= 64'(ua_p[0][63:31]) >= ub_p[0];
					zero_p[1] <= ub_p[0] == 64'd0;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					quo_p[k+1] <= {quo_p[k][QBITS-2:0], ge};
					sat_p[k+1] <= sat_p[k];
					zero_p[k+1] <= zero_p[k];
				end
			end
		end

		if (k < QBITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					ua_p[k+1] <= ua_p[k];
					ub_p[k+1] <= ub_p[k];
				end
			end
		end
	end

	// saturation and sign
	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_p[QBITS]) begin
				if (zero_p[QBITS]) begin
					res_s <= aneg_p[QBITS] ? -QMAX : QMAX;
				end else begin
					res_s <= neg_p[QBITS] ? -QMAX : QMAX;
				end
			end else begin
				res_s <= neg_p[QBITS] ? q32_t'(64'd0 - {1'b0, quo_p[QBITS]})
					: q32_t'({1'b0, quo_p[QBITS]});
			end
		end
	end

	assign q = res_s;

endmodule

[design/color_temperature_white_balance_gains.sv]
// Color temperature to white-balance gains. A temperature in kelvin (values
// below 1000 count as 1000) goes in on the slave stream; one request with three
// unsigned 2.6 gains against a D65 (6504 K) white point comes out on the master
// stream, with tuser set when any gain was clamped to 0..255. The design is a
// fully pipelined datapath: one temperature is accepted every clock cycle unless
// the master side stalls, and each passes LAT = 226 register stages. The depth
// is set mostly by the three chained dividers (63 quotient-bit stages each) plus
// the 4-stage multipliers. A stall on the master side freezes the whole pipeline.
module color_temperature_white_balance_gains import ctwb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // temperature_kelvin[14:0], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // gain_first, gain_second, gain_third, packed_gains
	output logic [0:0]  m_tuser   // clamped
);

	localparam int LAT = 1 + L_DIV + 2 * L_MUL + L_MUL + 2 + 2 * L_MUL + 2
		+ L_DIV + L_MUL + 1 + L_DIV + 1;

	logic           en;
	logic [LAT-1:0] vld_q;
	logic [14:0]    t_s1;
	logic           near_s1;
	logic [14:0]    t_in;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// clamp low temperatures, pick coefficient set
	assign t_in = (s_tdata[14:0] < 15'(T_MIN)) ? 15'(T_MIN) : s_tdata[14:0];
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_in;
			near_s1 <= (t_in >= 15'(T_NEAR_LO)) && (t_in <= 15'(T_NEAR_HI));
		end
	end

	// s = 1000 / T
	q32_t s, s2, s3, s_d1, s_d2, s2_d;
	logic near_x, near_c;

	ctwb_qdiv u_div_s (.clk, .en, .a(64'sd1000), .b(q32_t'({49'd0, t_s1})), .q(s));
	ctwb_qmul u_mul_s2 (.clk, .en, .a(s), .b(s), .p(s2));
	ctwb_delay #(.WIDTH(64), .DEPTH(L_MUL)) u_dly_s1 (.clk, .en, .d(s), .q(s_d1));
	ctwb_qmul u_mul_s3 (.clk, .en, .a(s2), .b(s_d1), .p(s3));
	ctwb_delay #(.WIDTH(64), .DEPTH(L_MUL)) u_dly_s2 (.clk, .en, .d(s_d1), .q(s_d2));
	ctwb_delay #(.WIDTH(64), .DEPTH(L_MUL)) u_dly_s2b (.clk, .en, .d(s2), .q(s2_d));
	ctwb_delay #(.WIDTH(1), .DEPTH(L_DIV + 2 * L_MUL)) u_dly_nx (
		.clk, .en, .d(near_s1), .q(near_x));
	ctwb_delay #(.WIDTH(1), .DEPTH(L_MUL)) u_dly_nc (.clk, .en, .d(near_x), .q(near_c));

	// cubic terms of x
	q32_t p0, p1, p2;
	q32_t xa_s1, xb_s1, x_s2;

	ctwb_qmul u_mul_p0 (.clk, .en, .a(near_x ? N0 : F0), .b(s3), .p(p0));
	ctwb_qmul u_mul_p1 (.clk, .en, .a(near_x ? N1 : F1), .b(s2_d), .p(p1));
	ctwb_qmul u_mul_p2 (.clk, .en, .a(near_x ? N2 : F2), .b(s_d2), .p(p2));

	// x sum
	always_ff @(posedge clk) begin
		if (en) begin
			xa_s1 <= p0 + p1;
			xb_s1 <= p2 + (near_c ? N3 : F3);
			x_s2 <= xa_s1 + xb_s1;
		end
	end

	// y = -3x^2 + 2.87x - 0.275
	q32_t m1, m2, m3, m2_d, x_d;
	q32_t y_s1, xy_s1, y_s2, x_s2b, nz_s2;

	ctwb_qmul u_mul_xx (.clk, .en, .a(x_s2), .b(x_s2), .p(m1));
	ctwb_qmul u_mul_lin (.clk, .en, .a(C287), .b(x_s2), .p(m2));
	ctwb_qmul u_mul_sq (.clk, .en, .a(CM3), .b(m1), .p(m3));
	ctwb_delay #(.WIDTH(64), .DEPTH(L_MUL)) u_dly_m2 (.clk, .en, .d(m2), .q(m2_d));
	ctwb_delay #(.WIDTH(64), .DEPTH(2 * L_MUL)) u_dly_x (.clk, .en, .d(x_s2), .q(x_d));

	// y, then 1 - x - y
	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= m3 + m2_d - C275;
			xy_s1 <= x_d;
			y_s2 <= y_s1;
			x_s2b <= xy_s1;
			nz_s2 <= QONE - xy_s1 - y_s1;
		end
	end

	// XYZ with Y = 1
	q32_t bx, bz;

	ctwb_qdiv u_div_bx (.clk, .en, .a(x_s2b), .b(y_s2), .q(bx));
	ctwb_qdiv u_div_bz (.clk, .en, .a(nz_s2), .b(y_s2), .q(bz));

	// cone response and gain division per channel
	q32_t rx [3];
	q32_t rz [3];
	q32_t r_s1 [3];
	q32_t gq [3];

	for (genvar i = 0; i < 3; i++) begin : g_ch
		ctwb_qmul u_mul_x (.clk, .en, .a(q32_t'(BRAD[i][0])), .b(bx), .p(rx[i]));
		ctwb_qmul u_mul_z (.clk, .en, .a(q32_t'(BRAD[i][2])), .b(bz), .p(rz[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				r_s1[i] <= rx[i] + q32_t'(BRAD[i][1]) + rz[i];
			end
		end

		ctwb_qdiv u_div_g (.clk, .en, .a(q32_t'(DST[i])), .b(r_s1[i]), .q(gq[i]));
	end

	// 2.6 truncation and clamp
	logic [7:0] g [3];
	logic [2:0] clip;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (gq[i][63]) begin
				g[i] = 8'd0;
				clip[i] = 1'b1;
			end else if (|gq[i][62:34]) begin
				g[i] = 8'hFF;
				clip[i] = 1'b1;
			end else begin
				g[i] = gq[i][33:26];
				clip[i] = 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {g[2], g[1], g[0], g[2], g[1], g[0]};
			m_tuser <= |clip;
		end
	end

endmodule

[design/ctwb_checker.sv]
module ctwb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output request changed");

	// input side accepts exactly when the pipeline moves
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// packed word repeats the three gains
	a_pack: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[47:24] == {m_tdata[23:16], m_tdata[15:8], m_tdata[7:0]})
		else $error("packed gains disagree with gain fields");

	// nothing comes out right after reset
	a_reset: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind color_temperature_white_balance_gains ctwb_checker u_ctwb_checker (.*);

[bench/color_temperature_white_balance_gains_test.sv]
module color_temperature_white_balance_gains_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [63:0] fix_t;

	typedef struct {
		logic [7:0]  g1;
		logic [7:0]  g2;
		logic [7:0]  g3;
		logic [23:0] pack;
		logic        clamp;
	} gains_t;

	localparam fix_t ONE = 64'sd4294967296;
	localparam fix_t BIG = 64'sh7FFF_FFFF_FFFF_FFFF;

	// decimal constant scaled by 2^32, truncated toward zero
	function automatic fix_t kq(input longint n, input longint d);
		return (n * ONE) / d;
	endfunction

	function automatic logic [63:0] absval(input fix_t a);
		return a < 0 ? 64'd0 - 64'(a) : 64'(a);
	endfunction

	function automatic fix_t signed_sat(input logic [63:0] m, input logic neg);
		if (m > 64'(BIG)) m = 64'(BIG);
		return neg ? -fix_t'(m) : fix_t'(m);
	endfunction

	function automatic fix_t fmul(input fix_t a, input fix_t b);
		logic [63:0] ua, ub, m;
		ua = absval(a);
		ub = absval(b);
		m = ((64'(ua[63:32]) * 64'(ub[63:32])) << 32) + 64'(ua[63:32]) * 64'(ub[31:0])
			+ 64'(ua[31:0]) * 64'(ub[63:32]) + ((64'(ua[31:0]) * 64'(ub[31:0])) >> 32);
		return signed_sat(m, (a < 0) != (b < 0));
	endfunction

	function automatic fix_t fdiv(input fix_t a, input fix_t b);
		logic [63:0] ua, ub, whole, rem, frac;
		logic neg;
		ua = absval(a);
		ub = absval(b);
		neg = (a < 0) != (b < 0);
		frac = 0;
		if (ub == 0) return signed_sat(64'(BIG), a < 0);
		whole = ua / ub;
		if (whole >= 64'd2147483648) return signed_sat(64'(BIG), neg);
		rem = ua % ub;
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= ub) begin
				rem = rem - ub;
				frac[0] = 1'b1;
			end
		end
		return signed_sat((whole << 32) | frac, neg);
	endfunction

	// bradford cone response of a daylight white at temperature t
	function automatic void cone(input int unsigned t, output fix_t r[3]);
		fix_t c[4], s, s2, s3, x, y, bx, bz;
		fix_t m[3][3];
		if (t >= 4000 && t <= 7000) begin
			c = '{kq(-46070, 10000), kq(29678, 10000), kq(9911, 100000), kq(244063, 1000000)};
		end else begin
			c = '{kq(-20064, 10000), kq(19018, 10000), kq(24748, 100000), kq(237040, 1000000)};
		end
		m = '{'{kq(8951, 10000), kq(2664, 10000), kq(-1614, 10000)},
			'{kq(-7502, 10000), kq(17135, 10000), kq(367, 10000)},
			'{kq(389, 10000), kq(-685, 10000), kq(10296, 10000)}};
		s = fix_t'((64'd1000 << 32) / 64'(t));
		s2 = fmul(s, s);
		s3 = fmul(s2, s);
		x = fmul(c[0], s3) + fmul(c[1], s2) + fmul(c[2], s) + c[3];
		y = fmul(kq(-3, 1), fmul(x, x)) + fmul(kq(287, 100), x) - kq(275, 1000);
		bx = fdiv(x, y);
		bz = fdiv(ONE - x - y, y);
		for (int i = 0; i < 3; i++) r[i] = fmul(m[i][0], bx) + m[i][1] + fmul(m[i][2], bz);
	endfunction

	function automatic gains_t white_balance(input logic [14:0] kelvin);
		int unsigned t;
		fix_t src[3], d65[3], q;
		logic [63:0] g[3];
		gains_t o;
		t = kelvin < 1000 ? 1000 : kelvin;
		cone(t, src);
		cone(6504, d65);
		o.clamp = 0;
		for (int i = 0; i < 3; i++) begin
			q = fdiv(d65[i], src[i]);
			if (q < 0) begin
				g[i] = 0;
				o.clamp = 1;
			end else begin
				g[i] = 64'(q) >> 26;
				if (g[i] > 255) begin
					g[i] = 255;
					o.clamp = 1;
				end
			end
		end
		o.g1 = g[0][7:0];
		o.g2 = g[1][7:0];
		o.g3 = g[2][7:0];
		o.pack = {o.g3, o.g2, o.g1};
		return o;
	endfunction

	class gains_board;
		gains_t pending[$];
		int errors;

		function void note_request(logic [14:0] kelvin);
			pending.push_back(white_balance(kelvin));
		endfunction

		function void check_result(logic [47:0] data, logic clamp);
			gains_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[7:0] !== e.g1) begin
				$error("gain_first expected %0d actual %0d", e.g1, data[7:0]);
				errors++;
			end
			if (data[15:8] !== e.g2) begin
				$error("gain_second expected %0d actual %0d", e.g2, data[15:8]);
				errors++;
			end
			if (data[23:16] !== e.g3) begin
				$error("gain_third expected %0d actual %0d", e.g3, data[23:16]);
				errors++;
			end
			if (data[47:24] !== e.pack) begin
				$error("packed_gains expected %h actual %h", e.pack, data[47:24]);
				errors++;
			end
			if (clamp !== e.clamp) begin
				$error("clamped expected %0d actual %0d", e.clamp, clamp);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // temperature_kelvin[14:0], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // gain_first, gain_second, gain_third, packed_gains
	logic [0:0]  m_tuser;   // clamped

	gains_board board;
	bit sending_done;

	color_temperature_white_balance_gains dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("color_temperature_white_balance_gains_test: errors");
		$finish;
	end

	// mostly short gaps, now and then a long one, sometimes none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_request(input logic [14:0] kelvin);
		int g;
		g = gap_len();
		repeat (g) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, kelvin};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_request(kelvin);
	endtask

	function automatic logic [14:0] rand_kelvin();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 15'($urandom_range(1000, 25000));
		if (r < 8) return 15'($urandom_range(3990, 7010));
		return 15'($urandom);
	endfunction

	// result side: random stalls
	initial begin
		int g;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
	end

	initial begin
		logic [14:0] directed[$];
		int waited;
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// below minimum, range edges, target white, top of field, bit patterns
		directed = '{0, 1, 999, 1000, 1001, 3999, 4000, 4001, 6503, 6504, 6505,
			6999, 7000, 7001, 10000, 24999, 25000, 25001, 32767, 16384, 21845, 10922};
		foreach (directed[i]) send_request(directed[i]);
		repeat (2000) send_request(rand_kelvin());
		s_tvalid <= 1'b0;
		waited = 0;
		while (board.pending.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (300) @(posedge clk);
		if (board.pending.size() == 0 && board.errors == 0)
			$display("color_temperature_white_balance_gains_test: clean");
		else
			$display("color_temperature_white_balance_gains_test: errors");
		$finish;
	end
endmodule

[sim.f]
design/ctwb_pkg.sv
design/ctwb_delay.sv
design/ctwb_qmul.sv
design/ctwb_qdiv.sv
design/color_temperature_white_balance_gains.sv
design/ctwb_checker.sv
bench/color_temperature_white_balance_gains_test.sv
